FILE: rtl/kbdrd_pkg.sv
`default_nettype none
package kbdrd_pkg;

    localparam int KEY_W            = 8;
    localparam int NUM_KEY_INPUTS   = 6;
    localparam int NUM_MODS         = 8;
    localparam int SET_SLOTS_DEF    = 14;
    localparam int REPORT_SLOTS_DEF = 6;

    // usage code of the first modifier (left control)
    localparam logic [KEY_W-1:0] MOD_BASE = 8'hE0;
    localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;

    typedef logic [KEY_W-1:0] key_t;

    // merge stage status seen by the sequencer
    typedef struct packed {
        logic busy;
    } merge_stat_t;

endpackage
`default_nettype wire

FILE: rtl/kbdrd_build.sv
`default_nettype none
module kbdrd_build #(
    parameter int SET_SLOTS    = kbdrd_pkg::SET_SLOTS_DEF,
    parameter int REPORT_SLOTS = kbdrd_pkg::REPORT_SLOTS_DEF
) (
    input  wire logic [kbdrd_pkg::NUM_MODS-1:0]                          modifier_bits,
    input  wire logic [kbdrd_pkg::NUM_KEY_INPUTS-1:0][kbdrd_pkg::KEY_W-1:0] keys,
    output      logic [SET_SLOTS-1:0][kbdrd_pkg::KEY_W-1:0]              cur_set
);
    import kbdrd_pkg::*;

    localparam int USED_A = (REPORT_SLOTS < NUM_KEY_INPUTS) ? REPORT_SLOTS : NUM_KEY_INPUTS;
    localparam int USED   = (USED_A < SET_SLOTS) ? USED_A : SET_SLOTS;

    // report codes first, then each set modifier into the first empty slot
    always_comb
    begin
        logic found;
        cur_set = '0;
        found   = 1'b0;
        for (int i = 0; i < USED; i++)
        begin
            cur_set[i] = keys[i];
        end
        for (int b = 0; b < NUM_MODS; b++)
        begin
            found = 1'b0;
            for (int i = 0; i < SET_SLOTS; i++)
            begin
                if (modifier_bits[b] && !found && cur_set[i] == KEY_NONE)
                begin
                    cur_set[i] = MOD_BASE + KEY_W'(b);
                    found      = 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/kbdrd_lane.sv
`default_nettype none
module kbdrd_lane #(
    parameter int SET_SLOTS = kbdrd_pkg::SET_SLOTS_DEF,
    parameter int IDX       = 0
) (
    input  wire logic [SET_SLOTS-1:0][kbdrd_pkg::KEY_W-1:0] own_set,
    input  wire logic [SET_SLOTS-1:0][kbdrd_pkg::KEY_W-1:0] other_set,
    output      logic                                       hit
);
    import kbdrd_pkg::*;

    // a slot counts when nonzero, first of its code, and absent from the other set
    always_comb
    begin
        logic dup;
        logic seen;
        dup  = 1'b0;
        seen = 1'b0;
        for (int j = 0; j < IDX; j++)
        begin
            if (own_set[j] == own_set[IDX])
            begin
                dup = 1'b1;
            end
        end
        for (int k = 0; k < SET_SLOTS; k++)
        begin
            if (other_set[k] == own_set[IDX])
            begin
                seen = 1'b1;
            end
        end
        hit = (own_set[IDX] != KEY_NONE) && !dup && !seen;
    end

endmodule
`default_nettype wire

FILE: rtl/kbdrd_merge.sv
`default_nettype none
module kbdrd_merge #(
    parameter int SET_SLOTS = kbdrd_pkg::SET_SLOTS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       load,
    input  wire logic [SET_SLOTS-1:0]                       press_hits,
    input  wire logic [SET_SLOTS-1:0]                       rel_hits,
    input  wire logic [SET_SLOTS-1:0][kbdrd_pkg::KEY_W-1:0] cur_set,
    input  wire logic [SET_SLOTS-1:0][kbdrd_pkg::KEY_W-1:0] held_set,
    input  wire logic                                       out_ready,
    output      logic                                       out_valid,
    output      logic [kbdrd_pkg::KEY_W-1:0]                event_key,
    output      logic                                       is_press,
    output      logic                                       last_event,
    output      kbdrd_pkg::merge_stat_t                     stat
);
    import kbdrd_pkg::*;

    logic [SET_SLOTS-1:0] press_mask_reg, press_mask_next;
    logic [SET_SLOTS-1:0] rel_mask_reg, rel_mask_next;
    logic                 out_valid_reg, out_valid_next;
    key_t                 key_reg, key_next;
    logic                 press_reg, press_next;
    logic                 last_reg, last_next;

    logic [SET_SLOTS-1:0] pick_mask;
    logic [SET_SLOTS-1:0] pick_onehot;
    logic                 pick_press;
    key_t                 pick_key;
    logic                 pending;
    logic                 advance;

    // presses go before releases, lowest slot first
    always_comb
    begin
        pending     = (press_mask_reg != '0) || (rel_mask_reg != '0);
        pick_press  = (press_mask_reg != '0);
        pick_mask   = pick_press ? press_mask_reg : rel_mask_reg;
        pick_onehot = pick_mask & (~pick_mask + SET_SLOTS'(1));
        pick_key    = '0;
        for (int i = 0; i < SET_SLOTS; i++)
        begin
            if (pick_onehot[i])
            begin
                pick_key = pick_key | (pick_press ? cur_set[i] : held_set[i]);
            end
        end
    end

    assign advance = pending && (!out_valid_reg || out_ready);

    // mask bookkeeping and output register
    always_comb
    begin
        press_mask_next = press_mask_reg;
        rel_mask_next   = rel_mask_reg;
        out_valid_next  = out_valid_reg;
        key_next        = key_reg;
        press_next      = press_reg;
        last_next       = last_reg;
        if (load)
        begin
            press_mask_next = press_hits;
            rel_mask_next   = rel_hits;
        end
        else if (advance)
        begin
            if (pick_press)
            begin
                press_mask_next = press_mask_reg & ~pick_onehot;
            end
            else
            begin
                rel_mask_next = rel_mask_reg & ~pick_onehot;
            end
            out_valid_next = 1'b1;
            key_next       = pick_key;
            press_next     = pick_press;
            last_next      = (press_mask_next == '0) && (rel_mask_next == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_mask_reg <= '0;
            rel_mask_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            press_mask_reg <= press_mask_next;
            rel_mask_reg   <= rel_mask_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        press_reg <= press_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_key   = key_reg;
    assign is_press    = press_reg;
    assign last_event  = last_reg;
    assign stat.busy   = pending || out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/keyboard_report_diff_core.sv
`default_nettype none
// keyboard report differencer
// input channel (in_valid/in_ready): one beat carries a boot keyboard report,
// modifier_bits plus key_a..key_f. output channel (out_valid/out_ready): one
// beat per key event, event_key with is_press, and last_event on the final
// event of a report. a report with no change gives no output beat.
// timing: the accept edge registers the key set, the next cycle runs the
// parallel compare lanes (one per slot for presses, one per slot for
// releases) and loads their hits into the merge stage, and the first event
// is registered on the output from the loaded masks in ST_EMIT. events then
// leave one per cycle from the single output register of the merge stage
// while out_ready is high. in_ready is high only when the previous report
// is fully drained, so a new report is not taken while events of the last
// one remain.
// a stall on out_ready holds the current beat and pauses the merge stage.
// reset empties the held key set (no keys held) and drops any pending event.
module keyboard_report_diff_core #(
    parameter int SET_SLOTS    = kbdrd_pkg::SET_SLOTS_DEF,
    parameter int REPORT_SLOTS = kbdrd_pkg::REPORT_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   modifier_bits,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   key_a,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   key_b,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   key_c,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   key_d,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   key_e,
    input  wire logic [kbdrd_pkg::KEY_W-1:0]   key_f,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [kbdrd_pkg::KEY_W-1:0]   event_key,
    output      logic                          is_press,
    output      logic                          last_event
);
    import kbdrd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [SET_SLOTS-1:0][KEY_W-1:0]      cur_reg, cur_next;
    logic [SET_SLOTS-1:0][KEY_W-1:0]      held_reg, held_next;
    logic [SET_SLOTS-1:0][KEY_W-1:0]      built_set;
    logic [NUM_KEY_INPUTS-1:0][KEY_W-1:0] keys;
    logic [SET_SLOTS-1:0]                 press_hits;
    logic [SET_SLOTS-1:0]                 rel_hits;
    logic                                 in_fire;
    logic                                 merge_load;
    merge_stat_t                          mstat;

    assign keys    = {key_f, key_e, key_d, key_c, key_b, key_a};
    assign in_fire = in_valid && in_ready;

    // current key set from the report
    kbdrd_build #(
        .SET_SLOTS    (SET_SLOTS),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_build (
        .modifier_bits (modifier_bits),
        .keys          (keys),
        .cur_set       (built_set)
    );

    // compare lanes: new keys and vanished keys
    for (genvar g = 0; g < SET_SLOTS; g++)
    begin : g_lane
        kbdrd_lane #(
            .SET_SLOTS (SET_SLOTS),
            .IDX       (g)
        ) u_press (
            .own_set   (cur_reg),
            .other_set (held_reg),
            .hit       (press_hits[g])
        );
        kbdrd_lane #(
            .SET_SLOTS (SET_SLOTS),
            .IDX       (g)
        ) u_rel (
            .own_set   (held_reg),
            .other_set (cur_reg),
            .hit       (rel_hits[g])
        );
    end

    // merge stage and output register
    kbdrd_merge #(
        .SET_SLOTS (SET_SLOTS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (merge_load),
        .press_hits (press_hits),
        .rel_hits   (rel_hits),
        .cur_set    (cur_reg),
        .held_set   (held_reg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .event_key  (event_key),
        .is_press   (is_press),
        .last_event (last_event),
        .stat       (mstat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        held_next  = held_reg;
        merge_load = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cur_next   = built_set;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                merge_load = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!mstat.busy)
                begin
                    held_next  = cur_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg <= built_set;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

endmodule
`default_nettype wire
